/* hw/rtl/sensor_frame_crc_check_and_scale_assert.svh */
// ----------------------------------------------------------------------------
// sensor frame checker assertion macros
// shared property forms for the concurrent checks of the rtl
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECK_AND_SCALE_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_SCALE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SFCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SFCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sfcc_pkg.sv */
// ----------------------------------------------------------------------------
// sensor frame checker package
// crc-8 constants and update function, frame record and queue status types
// ----------------------------------------------------------------------------
package sfcc_pkg;

    // crc-8, polynomial 0x31, msb first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // byte positions inside the nine-byte frame
    localparam logic [3:0] POS_FIRST   = 4'd0;
    localparam logic [3:0] POS_CO2_LO  = 4'd1;
    localparam logic [3:0] POS_TEMP_LO = 4'd4;
    localparam logic [3:0] POS_HUM_LO  = 4'd7;
    localparam logic [3:0] POS_LAST    = 4'd8;

    // scaling constants
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    // one checked frame handed from front to back
    typedef struct packed {
        logic        ok;
        logic [15:0] co2;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } frame_rec_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // one byte through the crc register, eight shift steps
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sfcc_front.sv */
// ----------------------------------------------------------------------------
// sensor frame front end
// tracks the byte position, checks the three word crcs and assembles words;
// pushes one frame record at the ninth byte
// ----------------------------------------------------------------------------
module sfcc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_acc,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               push,
    output sfcc_pkg::frame_rec_t rec
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       err_reg, err_next;
    logic [7:0] hi_reg;
    logic [15:0] co2_reg, temp_reg, hum_reg;

    logic [3:0]  eff_pos;
    logic [1:0]  phase;
    logic [15:0] word;

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    // resync on frame start, out-of-range position restarts
    assign eff_pos = (frame_start || (pos_reg > sfcc_pkg::POS_LAST)) ?
                     sfcc_pkg::POS_FIRST : pos_reg;
    assign word    = {hi_reg, data_byte};

    // byte role within its word
    always_comb begin
        unique case (eff_pos)
            4'd0, 4'd3, 4'd6: phase = PH_HIGH;
            4'd1, 4'd4, 4'd7: phase = PH_LOW;
            4'd2, 4'd5, 4'd8: phase = PH_CRC;
            default:          phase = PH_HIGH;
        endcase
    end

    // next crc, error flag and position
    always_comb begin
        crc_next = crc_reg;
        err_next = (eff_pos == sfcc_pkg::POS_FIRST) ? 1'b0 : err_reg;
        unique case (phase)
            PH_HIGH: crc_next = sfcc_pkg::crc_feed(sfcc_pkg::CRC_INIT, data_byte);
            PH_LOW:  crc_next = sfcc_pkg::crc_feed(crc_reg, data_byte);
            PH_CRC:  err_next = err_next | (crc_reg != data_byte);
            default: crc_next = crc_reg;
        endcase
        pos_next = (eff_pos == sfcc_pkg::POS_LAST) ? sfcc_pkg::POS_FIRST : eff_pos + 4'd1;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= sfcc_pkg::POS_FIRST;
            crc_reg <= sfcc_pkg::CRC_INIT;
            err_reg <= 1'b0;
        end else if (beat_acc) begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            err_reg <= err_next;
        end
    end

    // word assembly
    always_ff @(posedge aclk) begin
        if (beat_acc) begin
            if (phase == PH_HIGH) begin
                hi_reg <= data_byte;
            end
            if (eff_pos == sfcc_pkg::POS_CO2_LO) begin
                co2_reg <= word;
            end
            if (eff_pos == sfcc_pkg::POS_TEMP_LO) begin
                temp_reg <= word;
            end
            if (eff_pos == sfcc_pkg::POS_HUM_LO) begin
                hum_reg <= word;
            end
        end
    end

    // frame record at the last byte
    assign push         = beat_acc && (eff_pos == sfcc_pkg::POS_LAST);
    assign rec.ok       = !err_next;
    assign rec.co2      = co2_reg;
    assign rec.temp_raw = temp_reg;
    assign rec.hum_raw  = hum_reg;

endmodule

/* hw/rtl/sfcc_fifo.sv */
// ----------------------------------------------------------------------------
// sensor frame record queue
// short register queue between front end and scaling back end
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_check_and_scale_assert.svh"

module sfcc_fifo #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  sfcc_pkg::frame_rec_t wr_data,
    input  logic                 rd_en,
    output sfcc_pkg::frame_rec_t rd_data,
    output sfcc_pkg::fifo_stat_t stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    sfcc_pkg::frame_rec_t mem [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // checks
    `SFCC_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_FULL, "queue count overflow")
    `SFCC_ASSERT_NOW(a_no_wr_full, aclk, aresetn, stat.full, !wr_en, "record pushed into full queue")
    `SFCC_ASSERT_NEXT(a_wr_fill, aclk, aresetn, do_wr && !do_rd, !stat.empty, "queue empty after push")

endmodule

/* hw/rtl/sfcc_scale.sv */
// ----------------------------------------------------------------------------
// sensor frame scaling back end
// two-stage pipeline: products, then truncation and output register
// ----------------------------------------------------------------------------
module sfcc_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfcc_pkg::frame_rec_t rec,
    input  sfcc_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    output logic                 m_tuser
);

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic [15:0] s1_co2_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [15:0] out_co2_reg;
    logic [14:0] out_temp_reg;
    logic [13:0] out_hum_reg;

    logic        out_ready, s1_ready;
    logic [14:0] t_int;
    logic        t_round;
    logic [15:0] t_val;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = !stat.empty && s1_ready;

    // stage 1: scale products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= !stat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_ok_reg    <= rec.ok;
            s1_co2_reg   <= rec.co2;
            s1_tprod_reg <= 31'(sfcc_pkg::TEMP_SCALE) * 31'(rec.temp_raw);
            s1_hprod_reg <= 30'(sfcc_pkg::HUM_SCALE) * 30'(rec.hum_raw);
        end
    end

    // truncation toward zero: offset is a whole multiple of 65536, so
    // floor minus offset, plus one when negative with a nonzero fraction
    assign t_int   = s1_tprod_reg[30:16];
    assign t_round = (t_int < sfcc_pkg::TEMP_OFFSET) && (s1_tprod_reg[15:0] != 16'd0);
    assign t_val   = {1'b0, t_int} - {1'b0, sfcc_pkg::TEMP_OFFSET} + {15'd0, t_round};

    // stage 2: output register, zeros on a failed frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            out_ok_reg   <= s1_ok_reg;
            out_co2_reg  <= s1_ok_reg ? s1_co2_reg : 16'd0;
            out_temp_reg <= s1_ok_reg ? t_val[14:0] : 15'd0;
            out_hum_reg  <= s1_ok_reg ? s1_hprod_reg[29:16] : 14'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {3'b000, out_hum_reg, out_temp_reg, out_co2_reg};

endmodule

/* hw/rtl/sensor_frame_crc_check_and_scale.sv */
// ----------------------------------------------------------------------------
// sensor frame crc check and scale
// byte-wise frame checker with co2, temperature and humidity scaling
// ----------------------------------------------------------------------------
// Takes one frame byte per transfer and sustains one byte per clock: the
// crc-8 update of each byte is combinational logic in the front end. At the
// ninth byte of a frame the front end pushes one record into a short queue
// (FIFO_DEPTH records); the back end takes records through a two-stage
// pipeline (multiply, then truncate and register). s_tready drops only
// while the queue is full, which happens only when the output stalls
// long enough for FIFO_DEPTH results and more to back up.
module sensor_frame_crc_check_and_scale #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] co2_ppm, [30:16] temperature_centi,
                                   // [44:31] humidity_centi, [47:45] zero
    output logic        m_tuser    // [0] frame_ok
);

    sfcc_pkg::frame_rec_t wr_rec, rd_rec;
    sfcc_pkg::fifo_stat_t stat;
    logic                 push, pop, beat_acc;

    // input transfer
    assign s_tready = !stat.full;
    assign beat_acc = s_tvalid && s_tready;

    sfcc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_acc    (beat_acc),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .rec         (wr_rec)
    );

    sfcc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (wr_rec),
        .rd_en   (pop),
        .rd_data (rd_rec),
        .stat    (stat)
    );

    sfcc_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rec      (rd_rec),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* bench/tb_sensor_frame_crc_check_and_scale.sv */
// ----------------------------------------------------------------------------
// sensor frame crc check and scale testbench
// ----------------------------------------------------------------------------
// Streams nine-byte sensor frames into the checker one byte per transfer and
// compares every reading that comes out with an independent bit-accurate
// model of the crc-8 check and the co2, temperature and humidity scaling.
// A short table of hand-picked frames (all-zero and all-one words, a frame
// restart mid-frame, a back-to-back frame with a bad crc) runs first, then
// random frames: mostly well-formed with random words and occasional crc
// errors, plus truncated frames and raw byte noise. Both sides of the stream
// pause at random.
// ----------------------------------------------------------------------------
module tb_sensor_frame_crc_check_and_scale;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_GAP       = 10;
    localparam int RANDOM_BYTES  = 850;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 16;
    localparam int WATCHDOG_TIME = 2000000;

    // scaling, in hundredths
    localparam longint TEMP_GAIN         = 17500;
    localparam longint TEMP_OFFSET_CENTI = 4500;
    localparam longint HUM_GAIN          = 10000;

    // one reading as carried on the result stream
    typedef struct packed {
        logic               ok;
        logic [15:0]        co2;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } reading_t;

    // how a stimulus byte gets its value
    typedef enum logic [1:0] {
        BYTE_RAW,
        BYTE_CRC_OK,
        BYTE_CRC_BAD
    } byte_kind_e;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        byte_kind_e kind;
        logic       typed;
        reading_t   reading;
    } stim_row_t;

    localparam reading_t NO_READING   = '0;
    localparam reading_t ZERO_READING = '{ok: 1'b1, co2: 16'd0, temp: -15'sd4500,
                                          hum: 14'd0};
    localparam reading_t FULL_READING = '{ok: 1'b1, co2: 16'hFFFF, temp: 15'sd12999,
                                          hum: 14'd9999};

    localparam int DIRECTED_ROWS = 29;

    // hand-picked frames, crc bytes filled in from the model unless raw
    stim_row_t directed [DIRECTED_ROWS] = '{
        // all-zero words, every crc good
        '{8'h00, 1'b1, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b1, ZERO_READING},
        // partial frame dropped by the next frame start
        '{8'hFF, 1'b1, BYTE_RAW,     1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        // all-one words, every crc good
        '{8'hFF, 1'b1, BYTE_RAW,     1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'hFF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b1, FULL_READING},
        // back-to-back frame without start flag, bad crc on the middle word
        '{8'hBE, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'hEF, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, NO_READING},
        '{8'h12, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h34, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_BAD, 1'b0, NO_READING},
        '{8'h56, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h78, 1'b0, BYTE_RAW,     1'b0, NO_READING},
        '{8'h00, 1'b0, BYTE_CRC_OK,  1'b1, NO_READING}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // model state of the frame checker
    logic [3:0]  pred_pos      = sfcc_pkg::POS_FIRST;
    logic [7:0]  pred_crc      = sfcc_pkg::CRC_INIT;
    logic [7:0]  pred_hi       = 8'h00;
    logic [15:0] pred_co2      = 16'h0000;
    logic [15:0] pred_temp_raw = 16'h0000;
    logic [15:0] pred_hum_raw  = 16'h0000;
    logic        pred_err      = 1'b0;

    reading_t pending_readings [$];
    int       mismatch_count = 0;
    int       bytes_sent     = 0;
    int       next_gap       = 0;
    bit       sender_burst   = 1'b0;

    sensor_frame_crc_check_and_scale dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // crc-8 msb first, one input bit per step
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? sfcc_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // advance the model by one frame byte, returns 1 when a reading is due
    function automatic bit track_frame_byte(input logic [7:0] b, input logic start,
                                            output reading_t r);
        logic [3:0] p;
        longint     t;
        longint     h;
        p = pred_pos;
        r = NO_READING;
        if (start || p > sfcc_pkg::POS_LAST) p = sfcc_pkg::POS_FIRST;
        if (p == sfcc_pkg::POS_FIRST) pred_err = 1'b0;
        case (p % 3)
            0: begin
                pred_hi  = b;
                pred_crc = crc8_step(sfcc_pkg::CRC_INIT, b);
            end
            1: begin
                pred_crc = crc8_step(pred_crc, b);
                if (p == sfcc_pkg::POS_CO2_LO) pred_co2 = {pred_hi, b};
                else if (p == sfcc_pkg::POS_TEMP_LO) pred_temp_raw = {pred_hi, b};
                else pred_hum_raw = {pred_hi, b};
            end
            default: begin
                if (pred_crc != b) pred_err = 1'b1;
            end
        endcase
        if (p == sfcc_pkg::POS_LAST) begin
            pred_pos = sfcc_pkg::POS_FIRST;
            if (!pred_err) begin
                // signed division truncates toward zero
                t = (TEMP_GAIN * longint'(pred_temp_raw) - TEMP_OFFSET_CENTI * 65536) / 65536;
                h = (HUM_GAIN * longint'(pred_hum_raw)) >>> 16;
                r.ok   = 1'b1;
                r.co2  = pred_co2;
                r.temp = t[14:0];
                r.hum  = h[13:0];
            end
            return 1'b1;
        end
        pred_pos = p + 4'd1;
        return 1'b0;
    endfunction

    // one byte transfer; valid stays high only when the next byte follows at once
    task automatic send_byte(input logic [7:0] raw, input logic start, input byte_kind_e kind,
                             input logic typed, input reading_t typed_reading);
        logic [7:0] b;
        reading_t   r;
        bit         got;
        if (next_gap > 0) repeat (next_gap) @(posedge aclk);
        case (kind)
            BYTE_CRC_OK:  b = pred_crc;
            BYTE_CRC_BAD: b = pred_crc ^ 8'($urandom_range(1, 255));
            default:      b = raw;
        endcase
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = track_frame_byte(b, start, r);
        if (got) pending_readings.push_back(typed ? typed_reading : r);
        bytes_sent++;
        next_gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (next_gap > 0) s_tvalid <= 1'b0;
    endtask

    // first len bytes of a frame with random words, mostly good crcs
    task automatic send_frame(input logic start, input int len);
        logic [15:0] w;
        byte_kind_e  ck;
        w = 16'h0000;
        for (int i = 0; i < len; i++) begin
            if (i % 3 == 0) begin
                case ($urandom_range(0, 7))
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    default: w = 16'($urandom);
                endcase
            end
            ck = ($urandom_range(0, 9) == 0) ? BYTE_CRC_BAD : BYTE_CRC_OK;
            case (i % 3)
                0: send_byte(w[15:8], start && (i == 0), BYTE_RAW, 1'b0, NO_READING);
                1: send_byte(w[7:0], 1'b0, BYTE_RAW, 1'b0, NO_READING);
                default: send_byte(8'h00, 1'b0, ck, 1'b0, NO_READING);
            endcase
        end
    endtask

    // hold the sender until every outstanding reading has come back
    task automatic drain_readings();
        if (next_gap == 0) s_tvalid <= 1'b0;
        next_gap = 0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic check_reading();
        reading_t want;
        if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected reading, tdata %h tuser %b",
                                      m_tdata, m_tuser));
        end else begin
            want = pending_readings.pop_front();
            if (m_tuser !== want.ok)
                report_mismatch($sformatf("frame_ok %b, want %b", m_tuser, want.ok));
            if (m_tdata[15:0] !== want.co2)
                report_mismatch($sformatf("co2_ppm %0d, want %0d", m_tdata[15:0], want.co2));
            if (m_tdata[30:16] !== want.temp)
                report_mismatch($sformatf("temperature_centi %0d, want %0d",
                                          $signed(m_tdata[30:16]), want.temp));
            if (m_tdata[44:31] !== want.hum)
                report_mismatch($sformatf("humidity_centi %0d, want %0d",
                                          m_tdata[44:31], want.hum));
            if (m_tdata[47:45] !== 3'b000)
                report_mismatch($sformatf("tdata pad bits %b, want 000", m_tdata[47:45]));
        end
    endtask

    // result side monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_reading();
    end

    // result side ready with random stalls and calm stretches
    initial begin
        int stall;
        int calm_left;
        calm_left = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(5, 20);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus and end of run
    initial begin
        int mode;
        int waited;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames
        foreach (directed[i]) begin
            send_byte(directed[i].data, directed[i].start, directed[i].kind,
                      directed[i].typed, directed[i].reading);
        end
        drain_readings();

        // random frames, truncated frames and byte noise
        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 99);
            if (mode < 3) drain_readings();
            if (mode < 80) begin
                send_frame((pred_pos != sfcc_pkg::POS_FIRST) || ($urandom_range(0, 1) == 1),
                           9);
            end else if (mode < 92) begin
                send_frame(1'b1, $urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0, BYTE_RAW, 1'b0,
                              NO_READING);
                end
            end
        end
        if (next_gap == 0) s_tvalid <= 1'b0;

        // wait for the last readings, then keep watching for strays
        waited = 0;
        while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_readings.size() != 0)
            report_mismatch($sformatf("%0d expected readings never arrived",
                                      pending_readings.size()));
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run time limit
    initial begin
        #WATCHDOG_TIME;
        $display("FAILURE");
        $finish;
    end

endmodule
